FILE: rtl/pooled_slot_allocator_macros.svh
// Assertion macros for the pooled slot allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POOLED_SLOT_ALLOCATOR_MACROS_SVH
`define POOLED_SLOT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high
`define PSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pooled slot allocator check failed");
// Next-cycle implication, disabled while reset is high
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pooled slot allocator check failed");
`else
`define PSA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/psa_pkg.sv
// Shared types and constants of the pooled slot allocator.
// No dependencies; imported by psa_out_reg and pooled_slot_allocator.
`default_nettype none

package psa_pkg;

   // Field widths fixed by the request and response formats
   localparam int OP_W          = 1;
   localparam int POOL_ID_W     = 4;
   localparam int SLOT_W        = 5;
   localparam int STATUS_W      = 2;
   localparam int CFG_W         = 6;
   localparam int POOL_ID_RANGE = 1 << POOL_ID_W;

   // Reset value of the slots-per-pool register
   localparam logic [CFG_W-1:0] SLOTS_RESET = 6'd32;

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
   localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_POOL   = 2'd2;

   // One response
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [POOL_ID_W-1:0] got_pool;
      logic [SLOT_W-1:0]    got_slot;
      logic                 opened_pool;
      logic                 released_pool;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/psa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the slot bitmaps and the pool order list.
`default_nettype none

module psa_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [0:(1 << ADDR_W)-1];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/psa_out_reg.sv
// Response output register of the pooled slot allocator.
// Depends on psa_pkg for the response type.
`default_nettype none

module psa_out_reg
   import psa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire rsp_type push_data,
   output      logic    push_ready,
   output      logic    out_valid,
   input  wire logic    out_ready,
   output      rsp_type out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Take a new response when empty or when the held one leaves this cycle
   assign push_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until replaced
   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/pooled_slot_allocator.sv
// Top level of the pooled slot allocator: sequencer, registers and checks.
// Depends on psa_pkg, psa_ram, psa_out_reg and pooled_slot_allocator_macros.svh.
//
//   channel | ports  | direction | handshake
//   request | req_*  | in        | req_valid / req_ready
//   response| rsp_*  | out       | rsp_valid / rsp_ready
//   config  | csr_*  | in        | csr_wr_en, no wait
//
// Allocate: the order RAM read feeds the bitmap RAM read, one pool issued per cycle;
//   listed pools without room are skipped until the first with room gives a slot.
// Free: bitmap read, modify and write back, then hand-off; a free that empties
//   its pool also walks the order list to close the gap.
// One request is in work at a time; the next is taken once its response sits in
//   the output register, which holds it for as long as rsp_ready stays low.
// Reset needs no clearing pass: a pool's bitmap is written when the pool opens.
`default_nettype none
`include "pooled_slot_allocator_macros.svh"

module pooled_slot_allocator
   import psa_pkg::*;
#(
   parameter int MAX_POOLS = 16,
   parameter int MAX_SLOTS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [OP_W-1:0]      req_op,
   input  wire logic [POOL_ID_W-1:0] req_pool_id,
   input  wire logic [SLOT_W-1:0]    req_slot,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [STATUS_W-1:0]  rsp_status,
   output      logic [POOL_ID_W-1:0] rsp_got_pool,
   output      logic [SLOT_W-1:0]    rsp_got_slot,
   output      logic                 rsp_opened_pool,
   output      logic                 rsp_released_pool,
   input  wire logic                 csr_wr_en,
   input  wire logic [CFG_W-1:0]     csr_wr_data
);

   localparam int POOL_CAP = (MAX_POOLS < POOL_ID_RANGE) ? MAX_POOLS : POOL_ID_RANGE;
   localparam int IDX_W    = (POOL_CAP > 1) ? $clog2(POOL_CAP) : 1;
   localparam int CNT_W    = $clog2(POOL_CAP + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_FCHK   = 3'd2;
   localparam logic [2:0] S_FRD    = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // Control state
   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    spp_ff;
   logic [CNT_W-1:0]    open_cnt_ff, open_cnt_in;
   logic [POOL_CAP-1:0] pool_open_ff, pool_open_in;
   logic [CNT_W-1:0]    iss_ff, iss_in;
   logic                s1_ff, s1_in;
   logic                s2_ff, s2_in;
   logic                found_ff, found_in;

   // Request and walk payload
   logic [OP_W-1:0]      op_ff, op_in;
   logic [POOL_ID_W-1:0] pid_ff, pid_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     s1_idx_ff, s1_idx_in;
   logic [POOL_ID_W-1:0] s2_pool_ff, s2_pool_in;
   rsp_type              res_ff, res_in;

   // RAM ports
   logic                 ord_wr_en, ord_rd_en;
   logic [IDX_W-1:0]     ord_wr_addr, ord_rd_addr;
   logic [POOL_ID_W-1:0] ord_wr_data, ord_rd_data;
   logic                 bm_wr_en, bm_rd_en;
   logic [IDX_W-1:0]     bm_wr_addr, bm_rd_addr;
   logic [MAX_SLOTS-1:0] bm_wr_data, bm_rd_data;

   // Derived values
   logic [CFG_W-1:0]         n_eff;
   logic [MAX_SLOTS-1:0]     slot_mask;
   logic [MAX_SLOTS-1:0]     free_vec;
   logic [MAX_SLOTS-1:0]     low_bit;
   logic [SLOT_W-1:0]        low_idx;
   logic [MAX_SLOTS-1:0]     clr_bit;
   logic [MAX_SLOTS-1:0]     kept;
   logic [POOL_ID_W-1:0]     new_pool;
   logic                     new_ok;
   logic [POOL_CAP-1:0]      new_onehot;
   logic [POOL_CAP-1:0]      pid_onehot;
   logic [POOL_ID_RANGE-1:0] pool_open_ext;
   logic [CNT_W-1:0]         shift_idx;
   logic                     push_valid;
   logic                     push_ready;
   rsp_type                  out_data;

   // Pool order list
   psa_ram #(
      .WIDTH  (POOL_ID_W),
      .ADDR_W (IDX_W)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (ord_rd_en),
      .rd_addr (ord_rd_addr),
      .rd_data (ord_rd_data)
   );

   // Slot bitmaps, one word per pool
   psa_ram #(
      .WIDTH  (MAX_SLOTS),
      .ADDR_W (IDX_W)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // Clamp slot count and build the in-range mask
   always_comb begin
      if (spp_ff == '0) begin
         n_eff = CFG_W'(1);
      end else if (spp_ff > CFG_W'(MAX_SLOTS)) begin
         n_eff = CFG_W'(MAX_SLOTS);
      end else begin
         n_eff = spp_ff;
      end
      for (int k = 0; k < MAX_SLOTS; k++) begin
         slot_mask[k] = (CFG_W'(k) < n_eff);
         clr_bit[k]   = (SLOT_W'(k) == slot_ff);
      end
   end

   // Lowest free slot of the bitmap word just read
   assign free_vec = ~bm_rd_data & slot_mask;
   assign low_bit  = free_vec & (~free_vec + MAX_SLOTS'(1));
   assign kept     = bm_rd_data & ~clr_bit;

   always_comb begin
      low_idx = '0;
      for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
         if (free_vec[k]) begin
            low_idx = SLOT_W'(k);
         end
      end
   end

   // Lowest unused pool number and one-hot decodes
   always_comb begin
      new_pool = '0;
      new_ok   = 1'b0;
      for (int i = POOL_CAP - 1; i >= 0; i--) begin
         if (!pool_open_ff[i]) begin
            new_pool = POOL_ID_W'(i);
            new_ok   = 1'b1;
         end
      end
      for (int i = 0; i < POOL_CAP; i++) begin
         new_onehot[i] = (POOL_ID_W'(i) == new_pool);
         pid_onehot[i] = (POOL_ID_W'(i) == pid_ff);
      end
   end

   assign pool_open_ext = POOL_ID_RANGE'(pool_open_ff);
   assign shift_idx     = s1_idx_ff - CNT_W'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      open_cnt_in  = open_cnt_ff;
      pool_open_in = pool_open_ff;
      iss_in       = iss_ff;
      s1_in        = 1'b0;
      s2_in        = 1'b0;
      found_in     = found_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      slot_in      = slot_ff;
      s1_idx_in    = s1_idx_ff;
      s2_pool_in   = s2_pool_ff;
      res_in       = res_ff;
      ord_rd_en    = 1'b0;
      ord_rd_addr  = iss_ff[IDX_W-1:0];
      ord_wr_en    = 1'b0;
      ord_wr_addr  = '0;
      ord_wr_data  = '0;
      bm_rd_en     = 1'b0;
      bm_rd_addr   = '0;
      bm_wr_en     = 1'b0;
      bm_wr_addr   = '0;
      bm_wr_data   = '0;
      push_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Latch the request and start its walk
            if (req_valid) begin
               op_in         = req_op;
               pid_in        = req_pool_id;
               slot_in       = req_slot;
               iss_in        = '0;
               found_in      = 1'b0;
               res_in        = '0;
               res_in.status = STATUS_OK;
               state_in      = (req_op == OP_ALLOC) ? S_WALK : S_FCHK;
            end
         end

         S_WALK: begin
            // Issue the next order entry
            if (iss_ff < open_cnt_ff) begin
               ord_rd_en = 1'b1;
               s1_in     = 1'b1;
               iss_in    = iss_ff + CNT_W'(1);
            end
            // Order entry in hand: fetch its bitmap
            if (s1_ff) begin
               bm_rd_en   = 1'b1;
               bm_rd_addr = ord_rd_data[IDX_W-1:0];
               s2_in      = 1'b1;
               s2_pool_in = ord_rd_data;
            end
            // Bitmap in hand: take the lowest free slot, drop what is in flight
            if (s2_ff && (free_vec != '0)) begin
               bm_wr_en        = 1'b1;
               bm_wr_addr      = s2_pool_ff[IDX_W-1:0];
               bm_wr_data      = bm_rd_data | low_bit;
               res_in.got_pool = s2_pool_ff;
               res_in.got_slot = low_idx;
               s1_in           = 1'b0;
               s2_in           = 1'b0;
               state_in        = S_DONE;
            end else if (!s1_ff && !s2_ff && (iss_ff >= open_cnt_ff)) begin
               // No room anywhere: open a new pool at the list tail, or report no pool
               if ((open_cnt_ff < CNT_W'(POOL_CAP)) && new_ok) begin
                  bm_wr_en           = 1'b1;
                  bm_wr_addr         = new_pool[IDX_W-1:0];
                  bm_wr_data         = MAX_SLOTS'(1);
                  ord_wr_en          = 1'b1;
                  ord_wr_addr        = open_cnt_ff[IDX_W-1:0];
                  ord_wr_data        = new_pool;
                  open_cnt_in        = open_cnt_ff + CNT_W'(1);
                  pool_open_in       = pool_open_ff | new_onehot;
                  res_in.got_pool    = new_pool;
                  res_in.got_slot    = '0;
                  res_in.opened_pool = 1'b1;
               end else begin
                  res_in.status = STATUS_NO_POOL;
               end
               state_in = S_DONE;
            end
         end

         S_FCHK: begin
            // Refuse a closed pool or an out-of-range slot
            if (!pool_open_ext[pid_ff] || ({1'b0, slot_ff} >= n_eff)) begin
               res_in.status = STATUS_NOT_FOUND;
               state_in      = S_DONE;
            end else begin
               bm_rd_en   = 1'b1;
               bm_rd_addr = pid_ff[IDX_W-1:0];
               state_in   = S_FRD;
            end
         end

         S_FRD: begin
            // Clear the bit; release the pool once nothing in range is used
            bm_wr_en   = 1'b1;
            bm_wr_addr = pid_ff[IDX_W-1:0];
            if ((kept & slot_mask) == '0) begin
               bm_wr_data   = '0;
               iss_in       = '0;
               found_in     = 1'b0;
               state_in     = S_UNLINK;
            end else begin
               bm_wr_data = kept;
               state_in   = S_DONE;
            end
         end

         S_UNLINK: begin
            // Read the list in order
            if (iss_ff < open_cnt_ff) begin
               ord_rd_en = 1'b1;
               s1_in     = 1'b1;
               s1_idx_in = iss_ff;
               iss_in    = iss_ff + CNT_W'(1);
            end
            // Past the released pool, move each entry down by one
            if (s1_ff) begin
               if (found_ff) begin
                  ord_wr_en   = 1'b1;
                  ord_wr_addr = shift_idx[IDX_W-1:0];
                  ord_wr_data = ord_rd_data;
               end
               if (ord_rd_data == pid_ff) begin
                  found_in = 1'b1;
               end
            end else if (iss_ff >= open_cnt_ff) begin
               // Close the pool together with the count
               if (open_cnt_ff != '0) begin
                  open_cnt_in = open_cnt_ff - CNT_W'(1);
               end
               pool_open_in         = pool_open_ff & ~pid_onehot;
               res_in.released_pool = 1'b1;
               state_in             = S_DONE;
            end
         end

         S_DONE: begin
            // Hand the response to the output register
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         spp_ff       <= SLOTS_RESET;
         open_cnt_ff  <= '0;
         pool_open_ff <= '0;
         iss_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_cnt_ff  <= open_cnt_in;
         pool_open_ff <= pool_open_in;
         iss_ff       <= iss_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         found_ff     <= found_in;
         if (csr_wr_en) begin
            spp_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pid_ff     <= pid_in;
      slot_ff    <= slot_in;
      s1_idx_ff  <= s1_idx_in;
      s2_pool_ff <= s2_pool_in;
      res_ff     <= res_in;
   end

   psa_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (res_ff),
      .push_ready (push_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_status        = out_data.status;
   assign rsp_got_pool      = out_data.got_pool;
   assign rsp_got_slot      = out_data.got_slot;
   assign rsp_opened_pool   = out_data.opened_pool;
   assign rsp_released_pool = out_data.released_pool;

   // Checks
   `PSA_ASSERT_IMPL(a_cnt_bound, clock, reset, 1'b1, open_cnt_ff <= CNT_W'(POOL_CAP))
   `PSA_ASSERT_IMPL(a_cnt_matches_open, clock, reset, 1'b1, $countones(pool_open_ff) == int'(open_cnt_ff))
   `PSA_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   `PSA_ASSERT_IMPL(a_alloc_pool_open, clock, reset, push_valid && (res_ff.status == STATUS_OK) && (op_ff == OP_ALLOC), pool_open_ext[res_ff.got_pool])
   `PSA_ASSERT_IMPL(a_release_closed, clock, reset, push_valid && res_ff.released_pool, (op_ff == OP_FREE) && !pool_open_ext[pid_ff])

endmodule

`default_nettype wire
